>>> hw/rtl/ddpm_pkg.sv
// Package for the differential drive move controller.
// It holds the field widths, the request and mode codes, the sequencer states and the result record.
// It depends on nothing; the core and the checker import it.
package ddpm_pkg;

    // Field widths of the streaming channels and the configuration port.
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Bit positions of the input request fields in tdata.
    localparam int IN_MODE_LSB  = 0;
    localparam int IN_SPEED_LSB = 3;
    localparam int IN_DIST_LSB  = 11;
    localparam int IN_LP_LSB    = 19;
    localparam int IN_RP_LSB    = 23;

    // Bit positions of the result fields in tdata.
    localparam int OUT_LREV_BIT   = 16;
    localparam int OUT_RREV_BIT   = 17;
    localparam int OUT_MOVING_BIT = 18;
    localparam int OUT_DONE_BIT   = 19;

    // Internal widths.
    localparam int COUNT_W = 24;   // saturating encoder counts
    localparam int TGT_W   = 25;   // signed target count
    localparam int ERR_W   = 25;   // signed count difference
    localparam int DIFF_W  = 26;   // change of the count difference
    localparam int ACC_W   = 36;   // accumulator of the shared multiplier
    localparam int MUL_A_W = 17;   // signed multiplier operand A
    localparam int MUL_B_W = 26;   // signed multiplier operand B
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int DRIVE_LIMIT_DEF = 230;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_UNIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_LEFT_SQUARE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_LEFT_LINEAR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_RIGHT_SQUARE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_RIGHT_LINEAR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D           = 3'd6;

    // Request kinds, carried in tuser.
    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        MODE_STOP  = 3'd0,
        MODE_FWD   = 3'd1,
        MODE_REV   = 3'd2,
        MODE_ARC_L = 3'd3,
        MODE_ARC_R = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD_MUL,
        ST_ARC_SQ,
        ST_ARC_LIN,
        ST_ARC_RND,
        ST_TICK_ADD,
        ST_TICK_CMP,
        ST_TICK_P,
        ST_TICK_D,
        ST_TICK_CLAMP,
        ST_FIN
    } t_state;

    // Result record, first member in the highest bits so that left_pwm lands lowest.
    typedef struct packed {
        logic       done_res;
        logic       moving;
        logic       right_reverse;
        logic       left_reverse;
        logic [7:0] right_pwm;
        logic [7:0] left_pwm;
    } t_result;

endpackage

>>> hw/rtl/differential_drive_pd_mover_core.sv
// Differential drive move controller core: command decode, target calculation and PD steering.
// It depends on ddpm_pkg for widths, codes, the sequencer states and the result record.
// A single module; the checker in ddpm_checker.sv is bound to it.

// The block takes one request at a time on the slave stream and returns exactly one result on
// the master stream for it. A command request (tuser low) clears both encoder counts, stores the
// base speed and, for a moving mode, sets the target: counts_per_unit times distance for forward
// and reverse, or the signed Q8.8 quadratic in distance for arcs, truncated toward zero. A tick
// request (tuser high) in a move adds the encoder pulses; when either count reaches the target
// the move ends with zero drive and done_res set, otherwise the drives worked out on the previous
// tick are shown with the mode's wheel directions and new drives are computed from the PD
// correction. Products use one shared 17 by 26 bit signed multiplier with a 36 bit accumulator,
// stepped by a small sequencer, so a request occupies the block while the sequencer steps through
// it: a stop command or a tick while stopped goes straight to the finish step, a straight command
// forms its product, a tick that reaches the target updates the counts and compares, an arc
// command squares the distance, forms two products and rounds, and a tick that keeps the move
// going updates the counts, compares, forms two products and clamps. The result then sits in an
// output register, and the block takes the next request while that result waits to be taken. The
// configuration port is always ready and should only be written while no request is in flight.
module differential_drive_pd_mover_core #(
    parameter int DRIVE_LIMIT = ddpm_pkg::DRIVE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata from bit 0 up: mode[2:0], speed[7:0], distance[7:0], left_pulses[3:0],
    // right_pulses[3:0], zero fill
    input  logic [ddpm_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: op (0 command, 1 tick)
    input  logic [ddpm_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,
    // Result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata from bit 0 up: left_pwm[7:0], right_pwm[7:0], left_reverse, right_reverse,
    // moving, done_res, zero fill
    output logic [ddpm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ddpm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ddpm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ddpm_pkg::*;

    localparam logic signed [ACC_W:0] LimitExt = (ACC_W + 1)'(DRIVE_LIMIT);

    // Sequencer
    t_state r_state, n_state;

    // Configuration registers
    logic        [9:0]  r_counts_per_unit;
    logic signed [15:0] r_arc_l_sq, r_arc_l_lin, r_arc_r_sq, r_arc_r_lin;
    logic        [7:0]  r_gain_p, r_gain_d;

    // Move state
    t_mode                     r_move_mode;
    logic        [7:0]         r_base;
    logic        [COUNT_W-1:0] r_lcnt, r_rcnt;
    logic signed [TGT_W-1:0]   r_target;
    logic signed [ERR_W-1:0]   r_last_err;
    logic        [7:0]         r_ldrive, r_rdrive;

    // Request fields held for the duration of the work
    logic [7:0] r_dist;
    logic [3:0] r_lp, r_rp;

    // Working registers
    logic        [15:0]        r_dd;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DIFF_W-1:0]  r_diff;
    t_result                   r_res;

    // Output register
    logic    r_ov;
    t_result r_out;

    logic                      w_in_acc, w_fin_load;
    logic                      w_in_op;
    logic [2:0]                w_in_mode;
    logic                      w_mode_valid, w_mode_arc;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_prod_t, w_rnd;
    logic [COUNT_W:0]          w_lsum, w_rsum;
    logic signed [COUNT_W+1:0] w_lcnt_s, w_rcnt_s, w_tgt_s;
    logic                      w_reached;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [ACC_W:0]     w_base_ext, w_ldrv, w_rdrv;
    logic [7:0]                w_lclamp, w_rclamp;
    logic                      w_lback, w_rback;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fin_load = (r_state == ST_FIN) && (!r_ov || i_m_axis_tready);
    assign w_in_op    = i_s_axis_tuser[0];
    assign w_in_mode  = i_s_axis_tdata[IN_MODE_LSB +: 3];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_out};

    always_comb begin
        w_mode_valid = 1'b0;
        w_mode_arc   = 1'b0;
        case (w_in_mode)
            MODE_FWD, MODE_REV:     w_mode_valid = 1'b1;
            MODE_ARC_L, MODE_ARC_R: begin
                w_mode_valid = 1'b1;
                w_mode_arc   = 1'b1;
            end
            default: ;
        endcase
    end

    // Shared multiplier: operands are picked by the sequencer step.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_CMD_MUL: begin
                w_mul_a = (r_move_mode == MODE_ARC_L || r_move_mode == MODE_ARC_R)
                        ? $signed({9'b0, r_dist}) : $signed({7'b0, r_counts_per_unit});
                w_mul_b = $signed({18'b0, r_dist});
            end
            ST_ARC_SQ: begin
                w_mul_a = (r_move_mode == MODE_ARC_L) ? {r_arc_l_sq[15], r_arc_l_sq}
                                                      : {r_arc_r_sq[15], r_arc_r_sq};
                w_mul_b = $signed({10'b0, r_dd});
            end
            ST_ARC_LIN: begin
                w_mul_a = (r_move_mode == MODE_ARC_L) ? {r_arc_l_lin[15], r_arc_l_lin}
                                                      : {r_arc_r_lin[15], r_arc_r_lin};
                w_mul_b = $signed({18'b0, r_dist});
            end
            ST_TICK_P: begin
                w_mul_a = $signed({9'b0, r_gain_p});
                w_mul_b = {r_err[ERR_W-1], r_err};
            end
            ST_TICK_D: begin
                w_mul_a = $signed({9'b0, r_gain_d});
                w_mul_b = r_diff;
            end
            default: ;
        endcase
    end

    assign w_prod   = w_mul_a * w_mul_b;
    assign w_prod_t = w_prod[ACC_W-1:0];

    // Truncation of the arc sum toward zero: bias negative values before the shift.
    assign w_rnd = r_acc + (r_acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));

    // Saturating count update.
    assign w_lsum = {1'b0, r_lcnt} + {{(COUNT_W - 3){1'b0}}, r_lp};
    assign w_rsum = {1'b0, r_rcnt} + {{(COUNT_W - 3){1'b0}}, r_rp};

    // Target compare in a common signed width.
    assign w_lcnt_s  = $signed({2'b0, r_lcnt});
    assign w_rcnt_s  = $signed({2'b0, r_rcnt});
    assign w_tgt_s   = {r_target[TGT_W-1], r_target};
    assign w_reached = (w_lcnt_s >= w_tgt_s) || (w_rcnt_s >= w_tgt_s);
    assign w_err     = $signed({1'b0, r_lcnt}) - $signed({1'b0, r_rcnt});

    // Drive update: base minus and plus the correction, clamped to the drive range.
    assign w_base_ext = $signed({{(ACC_W - 7){1'b0}}, r_base});
    assign w_ldrv     = w_base_ext - {r_acc[ACC_W-1], r_acc};
    assign w_rdrv     = w_base_ext + {r_acc[ACC_W-1], r_acc};
    assign w_lclamp   = w_ldrv[ACC_W] ? 8'd0 : (w_ldrv > LimitExt) ? LimitExt[7:0] : w_ldrv[7:0];
    assign w_rclamp   = w_rdrv[ACC_W] ? 8'd0 : (w_rdrv > LimitExt) ? LimitExt[7:0] : w_rdrv[7:0];

    assign w_lback = (r_move_mode == MODE_REV) || (r_move_mode == MODE_ARC_L);
    assign w_rback = (r_move_mode == MODE_REV) || (r_move_mode == MODE_ARC_R);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_in_op == OP_CMD) begin
                        n_state = w_mode_valid ? ST_CMD_MUL : ST_FIN;
                    end else begin
                        n_state = (r_move_mode == MODE_STOP) ? ST_FIN : ST_TICK_ADD;
                    end
                end
            end
            ST_CMD_MUL: begin
                n_state = (r_move_mode == MODE_ARC_L || r_move_mode == MODE_ARC_R)
                        ? ST_ARC_SQ : ST_FIN;
            end
            ST_ARC_SQ:     n_state = ST_ARC_LIN;
            ST_ARC_LIN:    n_state = ST_ARC_RND;
            ST_ARC_RND:    n_state = ST_FIN;
            ST_TICK_ADD:   n_state = ST_TICK_CMP;
            ST_TICK_CMP:   n_state = w_reached ? ST_FIN : ST_TICK_P;
            ST_TICK_P:     n_state = ST_TICK_D;
            ST_TICK_D:     n_state = ST_TICK_CLAMP;
            ST_TICK_CLAMP: n_state = ST_FIN;
            ST_FIN: begin
                if (w_fin_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    // Configuration registers and the move state, all set to their reset values by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts_per_unit <= 10'd10;
            r_arc_l_sq        <= 16'sd0;
            r_arc_l_lin       <= 16'sd256;
            r_arc_r_sq        <= 16'sd0;
            r_arc_r_lin       <= 16'sd256;
            r_gain_p          <= 8'd12;
            r_gain_d          <= 8'd1;
            r_move_mode       <= MODE_STOP;
            r_base            <= '0;
            r_lcnt            <= '0;
            r_rcnt            <= '0;
            r_target          <= '0;
            r_last_err        <= '0;
            r_ldrive          <= '0;
            r_rdrive          <= '0;
            r_ov              <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_COUNTS_PER_UNIT:  r_counts_per_unit <= i_cfg_data[9:0];
                    REG_ARC_LEFT_SQUARE:  r_arc_l_sq        <= $signed(i_cfg_data);
                    REG_ARC_LEFT_LINEAR:  r_arc_l_lin       <= $signed(i_cfg_data);
                    REG_ARC_RIGHT_SQUARE: r_arc_r_sq        <= $signed(i_cfg_data);
                    REG_ARC_RIGHT_LINEAR: r_arc_r_lin       <= $signed(i_cfg_data);
                    REG_GAIN_P:           r_gain_p          <= i_cfg_data[7:0];
                    REG_GAIN_D:           r_gain_d          <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (w_fin_load) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && w_in_op == OP_CMD) begin
                        r_lcnt      <= '0;
                        r_rcnt      <= '0;
                        r_last_err  <= '0;
                        r_ldrive    <= '0;
                        r_rdrive    <= '0;
                        r_base      <= i_s_axis_tdata[IN_SPEED_LSB +: 8];
                        r_move_mode <= w_mode_valid ? t_mode'(w_in_mode) : MODE_STOP;
                    end
                end
                ST_CMD_MUL: begin
                    if (r_move_mode == MODE_FWD || r_move_mode == MODE_REV) begin
                        r_target <= w_prod[TGT_W-1:0];
                    end
                end
                ST_ARC_RND: begin
                    r_target <= w_rnd[TGT_W+7:8];
                end
                ST_TICK_ADD: begin
                    r_lcnt <= w_lsum[COUNT_W] ? {COUNT_W{1'b1}} : w_lsum[COUNT_W-1:0];
                    r_rcnt <= w_rsum[COUNT_W] ? {COUNT_W{1'b1}} : w_rsum[COUNT_W-1:0];
                end
                ST_TICK_CMP: begin
                    if (w_reached) begin
                        r_move_mode <= MODE_STOP;
                        r_ldrive    <= '0;
                        r_rdrive    <= '0;
                    end
                end
                ST_TICK_P: begin
                    r_last_err <= r_err;
                end
                ST_TICK_CLAMP: begin
                    r_ldrive <= w_lclamp;
                    r_rdrive <= w_rclamp;
                end
                default: ;
            endcase
        end
    end

    // Payload and working registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_out <= r_res;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_dist <= i_s_axis_tdata[IN_DIST_LSB +: 8];
                    r_lp   <= i_s_axis_tdata[IN_LP_LSB +: 4];
                    r_rp   <= i_s_axis_tdata[IN_RP_LSB +: 4];
                    // A command reports only whether a move has started.
                    r_res  <= t_result'({1'b0, (w_in_op == OP_CMD) && w_mode_valid, 18'b0});
                end
            end
            ST_CMD_MUL: begin
                r_dd <= w_prod[15:0];
            end
            ST_ARC_SQ: begin
                r_acc <= w_prod_t;
            end
            ST_ARC_LIN: begin
                r_acc <= r_acc + w_prod_t;
            end
            ST_TICK_CMP: begin
                r_err <= w_err;
                if (w_reached) begin
                    r_res <= t_result'({1'b1, 19'b0});
                end else begin
                    // The drives from the previous tick go out now.
                    r_res.left_pwm      <= r_ldrive;
                    r_res.right_pwm     <= r_rdrive;
                    r_res.left_reverse  <= w_lback && (r_ldrive != 8'd0);
                    r_res.right_reverse <= w_rback && (r_rdrive != 8'd0);
                    r_res.moving        <= 1'b1;
                    r_res.done_res      <= 1'b0;
                end
            end
            ST_TICK_P: begin
                r_acc  <= w_prod_t;
                r_diff <= {r_err[ERR_W-1], r_err} - {r_last_err[ERR_W-1], r_last_err};
            end
            ST_TICK_D: begin
                r_acc <= r_acc + w_prod_t;
            end
            default: ;
        endcase
    end

    logic w_unused_in;
    assign w_unused_in = ^{i_s_axis_tdata[IN_TDATA_W-1:IN_RP_LSB+4], r_dist[0]};

endmodule

>>> hw/rtl/ddpm_checker.sv
// Port-level checker for the differential drive move controller core.
// It depends on ddpm_pkg for field positions and is attached to the core by the bind below.
module ddpm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [ddpm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import ddpm_pkg::*;

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // One request at a time: the block is busy in the cycle after it takes one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while still busy");

    // A finished move is never reported as still moving.
    a_done_not_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[OUT_DONE_BIT] && o_m_axis_tdata[OUT_MOVING_BIT]))
        else $error("done and moving both set");

    // Without a move in progress both drives are zero and no wheel runs backward.
    a_idle_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[OUT_MOVING_BIT]
        |-> o_m_axis_tdata[OUT_RREV_BIT:0] == '0)
        else $error("drive shown without a move");

    // A reverse flag only accompanies a nonzero drive.
    a_reverse_needs_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[OUT_LREV_BIT] || o_m_axis_tdata[OUT_RREV_BIT])
        |-> (!o_m_axis_tdata[OUT_LREV_BIT] || o_m_axis_tdata[7:0] != 8'd0)
            && (!o_m_axis_tdata[OUT_RREV_BIT] || o_m_axis_tdata[15:8] != 8'd0))
        else $error("reverse flag on a zero drive");

endmodule

bind differential_drive_pd_mover_core ddpm_checker u_ddpm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> bench/differential_drive_pd_mover_core_test.sv
// Self-checking bench for the differential drive move controller core.
// Stream driver, result monitor and a behavioural predictor of moves and PD steering.
// Depends on ddpm_pkg and differential_drive_pd_mover_core only.
`timescale 1ns / 1ps

module differential_drive_pd_mover_core_test;
    import ddpm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // out of range, must be ignored
    localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] MODE_LAST_UNUSED  = 3'd7;
    localparam int COUNT_MAX    = (1 << COUNT_W) - 1;
    localparam int PHASE_QUOTA  = 320;
    localparam int HOLD_AT      = 600;    // requests taken before the long receiver hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;     // a little more than the slowest request

    typedef struct packed {
        logic       op;
        logic [2:0] mode;
        logic [7:0] speed;
        logic [7:0] span;
        logic [3:0] lp;
        logic [3:0] rp;
    } t_motion_req;

    // Clock, reset and block inputs, all known from time zero.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic [IN_TUSER_W-1:0]  s_user = '0;
    logic                   m_ready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   cfg_ready;

    differential_drive_pd_mover_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the registers, at their reset values.
    logic [9:0]         pulses_per_unit = 10'd10;
    logic signed [15:0] arc_l_sq = 16'sd0;
    logic signed [15:0] arc_l_lin = 16'sd256;
    logic signed [15:0] arc_r_sq = 16'sd0;
    logic signed [15:0] arc_r_lin = 16'sd256;
    logic [7:0]         kp = 8'd12;
    logic [7:0]         kd = 8'd1;

    // Predictor copy of the move state.
    int         cnt_left = 0;
    int         cnt_right = 0;
    longint     goal_count = 0;
    longint     prev_diff = 0;
    logic [7:0] drv_left = '0;
    logic [7:0] drv_right = '0;
    logic [2:0] run_mode = MODE_STOP;
    logic [7:0] cruise = '0;

    t_motion_req pending_reqs[$];
    t_result     move_results[$];
    t_motion_req cur_req;
    t_motion_req nxt;
    t_result     got;
    t_result     want;
    int src_gap = 0;
    int sink_stall = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;
    bit quiet = 1'b0;
    int reqs_issued = 0;
    int reqs_taken = 0;
    int results_seen = 0;
    int errors = 0;
    int n_cmds = 0;
    int n_ticks = 0;
    int n_arrivals = 0;
    int n_settings = 1;

    task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
        $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got_v,
                 want_v);
        errors++;
    endtask

    // Target count of a move, truncated toward zero for the arcs.
    function automatic longint move_target(input logic [2:0] mode, input logic [7:0] span);
        longint d;
        d = longint'(span);
        case (mode)
            MODE_ARC_L: return (longint'(arc_l_sq) * d * d + longint'(arc_l_lin) * d) / 256;
            MODE_ARC_R: return (longint'(arc_r_sq) * d * d + longint'(arc_r_lin) * d) / 256;
            default:    return longint'(pulses_per_unit) * d;
        endcase
    endfunction

    function automatic logic [7:0] clamp_drive(input longint v);
        if (v > DRIVE_LIMIT_DEF) return 8'(DRIVE_LIMIT_DEF);
        if (v < 0) return 8'd0;
        return v[7:0];
    endfunction

    // One request through the move controller; returns the result it should produce.
    function automatic t_result step_motion(input t_motion_req r);
        t_result res;
        longint  diff;
        longint  corr;
        res = '0;
        if (r.op == OP_CMD) begin
            n_cmds++;
            cnt_left = 0;
            cnt_right = 0;
            prev_diff = 0;
            drv_left = '0;
            drv_right = '0;
            cruise = r.speed;
            case (r.mode)
                MODE_FWD, MODE_REV, MODE_ARC_L, MODE_ARC_R: begin
                    goal_count = move_target(r.mode, r.span);
                    run_mode = r.mode;
                end
                default: run_mode = MODE_STOP;
            endcase
        end else begin
            n_ticks++;
            if (run_mode != MODE_STOP) begin
                cnt_left = cnt_left + int'(r.lp);
                cnt_right = cnt_right + int'(r.rp);
                if (cnt_left > COUNT_MAX) cnt_left = COUNT_MAX;
                if (cnt_right > COUNT_MAX) cnt_right = COUNT_MAX;
                if (longint'(cnt_left) >= goal_count || longint'(cnt_right) >= goal_count) begin
                    // Target reached: drives drop to zero and the move ends.
                    res.done_res = 1'b1;
                    n_arrivals++;
                    run_mode = MODE_STOP;
                    drv_left = '0;
                    drv_right = '0;
                end else begin
                    // Show the drives of the previous tick, then steer.
                    res.left_pwm = drv_left;
                    res.right_pwm = drv_right;
                    res.left_reverse = (run_mode == MODE_REV || run_mode == MODE_ARC_L)
                                       && drv_left != 0;
                    res.right_reverse = (run_mode == MODE_REV || run_mode == MODE_ARC_R)
                                        && drv_right != 0;
                    diff = longint'(cnt_left) - longint'(cnt_right);
                    corr = longint'(kp) * diff + longint'(kd) * (diff - prev_diff);
                    prev_diff = diff;
                    drv_left = clamp_drive(longint'(cruise) - corr);
                    drv_right = clamp_drive(longint'(cruise) + corr);
                end
            end
        end
        res.moving = run_mode != MODE_STOP;
        return res;
    endfunction

    // Request driver: offers the pending requests, with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                move_results.push_back(step_motion(cur_req));
                reqs_taken++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    nxt = pending_reqs.pop_front();
                    cur_req <= nxt;
                    s_data <= {{(IN_TDATA_W - 27){1'b0}}, nxt.rp, nxt.lp, nxt.span, nxt.speed,
                               nxt.mode};
                    s_user <= nxt.op;
                    s_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 8);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off, so that the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (!hold_used && reqs_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: checks each result against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                got = t_result'(m_data[$bits(t_result)-1:0]);
                if (move_results.size() == 0) begin
                    report_mismatch("result with nothing predicted", got, 0);
                end else begin
                    want = move_results.pop_front();
                    if (got.left_pwm != want.left_pwm)
                        report_mismatch("left_pwm", got.left_pwm, want.left_pwm);
                    if (got.right_pwm != want.right_pwm)
                        report_mismatch("right_pwm", got.right_pwm, want.right_pwm);
                    if (got.left_reverse != want.left_reverse)
                        report_mismatch("left_reverse", got.left_reverse, want.left_reverse);
                    if (got.right_reverse != want.right_reverse)
                        report_mismatch("right_reverse", got.right_reverse, want.right_reverse);
                    if (got.moving != want.moving)
                        report_mismatch("moving", got.moving, want.moving);
                    if (got.done_res != want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= (hold_left == 0);
            end
        end
    end

    task automatic add_req(input logic op, input logic [2:0] mode, input logic [7:0] speed,
                           input logic [7:0] span, input logic [3:0] lp, input logic [3:0] rp);
        t_motion_req r;
        r.op = op;
        r.mode = mode;
        r.speed = speed;
        r.span = span;
        r.lp = lp;
        r.rp = rp;
        pending_reqs.push_back(r);
        reqs_issued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_COUNTS_PER_UNIT:  pulses_per_unit = val[9:0];
            REG_ARC_LEFT_SQUARE:  arc_l_sq = val;
            REG_ARC_LEFT_LINEAR:  arc_l_lin = val;
            REG_ARC_RIGHT_SQUARE: arc_r_sq = val;
            REG_ARC_RIGHT_LINEAR: arc_r_lin = val;
            REG_GAIN_P:           kp = val[7:0];
            REG_GAIN_D:           kd = val[7:0];
            default: ;
        endcase
    endtask

    // Upper data bits beyond a register's width are filled with noise.
    task automatic load_settings(input int cpu, input int lsq, input int llin, input int rsq,
                                 input int rlin, input int p, input int d);
        write_reg(REG_COUNTS_PER_UNIT, {6'($urandom), 10'(cpu)});
        write_reg(REG_ARC_LEFT_SQUARE, 16'(lsq));
        write_reg(REG_ARC_LEFT_LINEAR, 16'(llin));
        write_reg(REG_ARC_RIGHT_SQUARE, 16'(rsq));
        write_reg(REG_ARC_RIGHT_LINEAR, 16'(rlin));
        write_reg(REG_GAIN_P, {8'($urandom), 8'(p)});
        write_reg(REG_GAIN_D, {8'($urandom), 8'(d)});
        n_settings++;
    endtask

    task automatic wait_drained;
        while (results_seen != reqs_issued) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly whole moves with random content: a command followed by enough ticks to reach
    // the target, sometimes cut short by the next command, plus ticks while stopped.
    task automatic random_phase(input int quota, input int dmax);
        int         made;
        int         n;
        int         est;
        int         style;
        longint     tgt;
        logic [2:0] mode;
        logic [7:0] span;
        logic [3:0] lp;
        logic [3:0] rp;
        made = 0;
        while (made < quota) begin
            n = $urandom_range(0, 19);
            if (n < 2) mode = MODE_STOP;
            else if (n < 3) mode = 3'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
            else mode = 3'($urandom_range(MODE_FWD, MODE_ARC_R));
            span = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, dmax));
            add_req(OP_CMD, mode, 8'($urandom), span, 4'($urandom), 4'($urandom));
            made++;
            if (mode inside {MODE_FWD, MODE_REV, MODE_ARC_L, MODE_ARC_R}) begin
                tgt = move_target(mode, span);
                est = (tgt <= 0) ? 1 : ((tgt / 7 > 60) ? 60 : int'(tgt / 7) + 1);
                n = $urandom_range(1, est + 3);
                if ($urandom_range(0, 7) == 0) n = $urandom_range(0, est);
                made += n;
            end else begin
                n = $urandom_range(0, 3);
            end
            style = $urandom_range(0, 3);
            repeat (n) begin
                lp = 4'($urandom);
                case (style)
                    1: rp = lp;
                    2: rp = (lp > 2) ? lp - 4'($urandom_range(0, 2)) : lp;
                    3: begin
                        lp = $urandom_range(0, 1) ? 4'hF : 4'h0;
                        rp = $urandom_range(0, 1) ? 4'hF : 4'h0;
                    end
                    default: rp = 4'($urandom);
                endcase
                add_req(OP_TICK, 3'($urandom), 8'($urandom), 8'($urandom), lp, rp);
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests at the reset settings.
        add_req(OP_TICK, MODE_LAST_UNUSED, 8'hFF, 8'hFF, 4'hF, 4'hF);  // tick while stopped
        add_req(OP_CMD, MODE_FWD, 8'hFF, 8'd0, 4'h0, 4'h0);             // zero target
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'h0, 4'h0);
        add_req(OP_CMD, MODE_REV, 8'd200, 8'd1, 4'h0, 4'h0);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'd3, 4'd2);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'd3, 4'd1);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'd2, 4'd4);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'd5, 4'd5);
        add_req(OP_CMD, MODE_ARC_L, 8'd100, 8'd2, 4'h0, 4'h0);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'd1, 4'd0);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'd0, 4'd0);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'd1, 4'd0);
        add_req(OP_CMD, MODE_ARC_R, 8'd0, 8'hFF, 4'h0, 4'h0);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'h0, 4'hF);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'hF, 4'h0);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'h0, 4'h0);
        add_req(OP_CMD, MODE_STOP, 8'hFF, 8'hFF, 4'hF, 4'hF);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'hF, 4'hF);
        add_req(OP_CMD, MODE_FIRST_UNUSED, 8'hAA, 8'h55, 4'hA, 4'h5);
        add_req(OP_CMD, MODE_FIRST_UNUSED + 3'd1, 8'h55, 8'hAA, 4'h5, 4'hA);
        add_req(OP_CMD, MODE_LAST_UNUSED, 8'hFF, 8'hFF, 4'hF, 4'hF);
        add_req(OP_CMD, MODE_FWD, 8'hFF, 8'hFF, 4'h0, 4'h0);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'hF, 4'h0);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'h0, 4'hF);
        add_req(OP_TICK, MODE_STOP, 8'd0, 8'd0, 4'hF, 4'hF);
        wait_drained();

        // Fixed settings: no steering, then the extremes, then negative arc targets.
        write_reg(REG_UNUSED, 16'hFFFF);
        load_settings(1, 64, 512, 32, 768, 0, 0);
        random_phase(PHASE_QUOTA, 12);
        load_settings(1023, -32768, 32767, 32767, -32768, 255, 255);
        random_phase(PHASE_QUOTA - 70, 1);
        load_settings(3, 256, -256, -256, 2000, 1, 0);
        random_phase(PHASE_QUOTA, 10);

        // Random settings; the last phase runs with no idling on either side.
        repeat (3) begin
            if (n_settings == 6) quiet = 1'b1;
            load_settings($urandom_range(1, 16),
                          int'($urandom_range(0, 1280)) - 256,
                          int'($urandom_range(0, 3072)) - 512,
                          int'($urandom_range(0, 1280)) - 256,
                          int'($urandom_range(0, 3072)) - 512,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 20),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 20));
            random_phase(PHASE_QUOTA, 8);
        end

        if (move_results.size() != 0)
            report_mismatch("predicted results never delivered", move_results.size(), 0);
        $display("Ran %0d requests (%0d commands, %0d ticks) over %0d register settings;",
                 reqs_taken, n_cmds, n_ticks, n_settings);
        $display("%0d moves reached their target, %0d result mismatches.", n_arrivals, errors);
        if (errors == 0) begin
            $display("differential_drive_pd_mover_core_test OK");
        end else begin
            $display("differential_drive_pd_mover_core_test NOT OK");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #5_000_000;
        $display("Watchdog expired with %0d of %0d results seen.", results_seen, reqs_issued);
        $display("differential_drive_pd_mover_core_test NOT OK");
        $finish;
    end

endmodule

>>> differential_drive_pd_mover_core.f
hw/rtl/ddpm_pkg.sv
hw/rtl/differential_drive_pd_mover_core.sv
hw/rtl/ddpm_checker.sv
bench/differential_drive_pd_mover_core_test.sv
